@@ design/sagc_pkg.sv @@
// Shared types, constants and tables for the slice auto gamma correction block.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sagc_pkg;

    localparam int PIX_W      = 16;
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIV_N_W    = 34;
    localparam int DIV_D_W    = 21;
    localparam int LOG_STEPS  = 16;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [20:0] LOG_TOP = 21'h100000;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIN,
        ST_W_RD,
        ST_W_LOAD,
        ST_W_NORM,
        ST_AVG,
        ST_AVG_DIV,
        ST_LOG_TGT,
        ST_LOG_AVG,
        ST_G_DIV,
        ST_F_RD,
        ST_F_NORM,
        ST_F_LOG,
        ST_F_T,
        ST_F_POW,
        ST_F_SHIFT,
        ST_F_SCALE,
        ST_F_PUT
    } sagc_state_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        rem   = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // c_i = 2^30 * 2^(-2^-i), built by repeated square roots
    function automatic logic [29:0] pow_coef(input int idx);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 1; i <= idx; i++) begin
            c = isqrt64(c << 30);
        end
        return c[29:0];
    endfunction

    localparam logic [29:0] POW_COEF [LOG_STEPS] = '{
        pow_coef(1),  pow_coef(2),  pow_coef(3),  pow_coef(4),
        pow_coef(5),  pow_coef(6),  pow_coef(7),  pow_coef(8),
        pow_coef(9),  pow_coef(10), pow_coef(11), pow_coef(12),
        pow_coef(13), pow_coef(14), pow_coef(15), pow_coef(16)
    };

endpackage

`default_nettype wire

@@ design/sagc_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on sagc_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

interface sagc_req_if import sagc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [PIX_W-1:0] pixel_in;
    logic                    slice_end;

    modport source (output valid, req_type, pixel_in, slice_end, input ready);
    modport sink   (input valid, req_type, pixel_in, slice_end, output ready);
endinterface

interface sagc_rsp_if import sagc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_out;
    logic                    last_out;
    logic [15:0]             gamma_used;

    modport source (output valid, pixel_out, last_out, gamma_used, input ready);
    modport sink   (input valid, pixel_out, last_out, gamma_used, output ready);
endinterface

`default_nettype wire

@@ design/slice_auto_gamma_correct.sv @@
// Slice auto gamma correction: pixel store, sequencer, shared divider and multiplier.
// Depends on sagc_pkg and the channel interfaces in sagc_if.sv.
//
// Usage: req carries words of two kinds. A load word (req_type 0) stores one pixel;
// slice_end on it closes the slice. The block then walks the stored slice once,
// running the normalizing divide for each pixel, and then the average divide, two
// 16-step logarithms and the gamma divide. req.ready is low during the walk. A fetch
// word (req_type 1) returns one corrected pixel on rsp, in load order, through a
// 34-step divide, a 16-step log and a 16-step power series, all on the one divider
// and one 32x32 multiplier; a pixel that passes unchanged skips them. The block takes
// one word at a time.
// The result sits in an output register; the block accepts the next word while it
// waits. When rsp stalls, a finished fetch holds until the register frees up.
// Reset (rst_n low, asynchronous) empties the slice, sets gamma to 1.0 and loads the
// register defaults; no clearing pass runs. Registers: target_level at 0x0,
// count_threshold at 0x4 over the APB port; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module slice_auto_gamma_correct import sagc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    sagc_req_if.sink         req,
    sagc_rsp_if.source       rsp
);

    sagc_state_t state_reg, state_next;

    logic                    phase_reg, phase_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rp_reg, rp_next;
    logic signed [PIX_W-1:0] min_reg, min_next;
    logic signed [PIX_W-1:0] max_reg, max_next;
    logic [15:0]             gamma_reg, gamma_next;
    logic [15:0]             tgt_reg, tgt_next;
    logic [15:0]             thr_reg, thr_next;
    logic signed [PIX_W-1:0] base_reg, base_next;
    logic [15:0]             range_reg, range_next;
    logic                    flat_reg, flat_next;
    logic                    last_reg, last_next;
    logic [28:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [15:0]             avg_reg, avg_next;
    logic [20:0]             lg_reg, lg_next;
    logic [DIV_N_W-1:0]      div_num_reg, div_num_next;
    logic [DIV_D_W-1:0]      div_den_reg, div_den_next;
    logic [DIV_D_W-1:0]      div_rem_reg, div_rem_next;
    logic [DIV_N_W-1:0]      div_quo_reg, div_quo_next;
    logic [5:0]              step_reg, step_next;
    logic [30:0]             log_m_reg, log_m_next;
    logic [15:0]             log_frac_reg, log_frac_next;
    logic [3:0]              log_e_reg, log_e_next;
    logic [30:0]             pow_r_reg, pow_r_next;
    logic [15:0]             pow_f_reg, pow_f_next;
    logic [4:0]              pow_k_reg, pow_k_next;
    logic [16:0]             pw_reg, pw_next;
    logic signed [PIX_W-1:0] res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [PIX_W-1:0] out_pix_reg, out_pix_next;
    logic                    out_last_reg, out_last_next;
    logic [15:0]             out_gamma_reg, out_gamma_next;

    logic signed [PIX_W-1:0] mem [MAX_PIXELS];
    logic signed [PIX_W-1:0] mem_q_reg;

    logic              req_acc;
    logic              cfg_we;
    logic              mem_we;
    logic              step_last;
    logic              slot_free;
    logic              rp_is_last;
    logic              flat_now;
    logic [15:0]       tgt_eff;
    logic [21:0]       div_shift;
    logic              div_ge;
    logic [DIV_D_W-1:0] div_rem_step;
    logic [DIV_N_W-1:0] div_quo_step;
    logic [DIV_N_W-1:0] div_num_step;
    logic [16:0]       n_q;
    logic [16:0]       norm_d;
    logic [DIV_N_W-1:0] norm_num;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [31:0]       log_sq;
    logic [30:0]       log_m_step;
    logic [15:0]       log_frac_step;
    logic [20:0]       neglog_step;
    logic [15:0]       log_x;
    logic [3:0]        log_e_x;
    logic [30:0]       log_m_x;
    logic [63:0]       pow_sum;
    logic [36:0]       t_sum;
    logic [8:0]        t_k;
    logic [44:0]       pow_round;
    logic [44:0]       pow_shift;
    logic [32:0]       scale_sum;
    logic [16:0]       scale_res;

    assign pready    = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign cfg_we    = psel && penable && pwrite && pready;
    assign step_last = (step_reg == 6'd0);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign rp_is_last = (CNT_W'(rp_reg + 1'b1) == count_reg);
    assign flat_now  = !(max_reg > min_reg);
    assign tgt_eff   = (tgt_reg == 16'd0) ? 16'd1 : tgt_reg;
    assign mem_we    = req_acc && (req.req_type == REQ_LOAD) && !phase_reg
                       && !count_reg[CNT_W-1];

    assign rsp.valid      = out_valid_reg;
    assign rsp.pixel_out  = out_pix_reg;
    assign rsp.last_out   = out_last_reg;
    assign rsp.gamma_used = out_gamma_reg;

    always_comb
    begin
        unique case (paddr[2])
            REG_TARGET: prdata = {16'd0, tgt_reg};
            REG_THRESH: prdata = {16'd0, thr_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // shared restoring divider, one quotient bit a cycle
    assign div_shift    = {div_rem_reg, div_num_reg[DIV_N_W-1]};
    assign div_ge       = (div_shift >= {1'b0, div_den_reg});
    assign div_rem_step = div_ge ? DIV_D_W'(div_shift - {1'b0, div_den_reg})
                                 : div_shift[DIV_D_W-1:0];
    assign div_quo_step = {div_quo_reg[DIV_N_W-2:0], div_ge};
    assign div_num_step = {div_num_reg[DIV_N_W-2:0], 1'b0};
    assign n_q          = div_quo_step[16:0];

    assign norm_d   = {mem_q_reg[PIX_W-1], mem_q_reg} - {base_reg[PIX_W-1], base_reg};
    assign norm_num = DIV_N_W'({norm_d[15:0], 16'd0}) + DIV_N_W'(range_reg[15:1]);

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_LOG_TGT, ST_LOG_AVG, ST_F_LOG:
            begin
                mul_a = {1'b0, log_m_reg};
                mul_b = {1'b0, log_m_reg};
            end
            ST_F_T:
            begin
                mul_a = {11'd0, lg_reg};
                mul_b = {16'd0, gamma_reg};
            end
            ST_F_POW:
            begin
                mul_a = {1'b0, pow_r_reg};
                mul_b = {2'd0, POW_COEF[4'd15 - step_reg[3:0]]};
            end
            ST_F_SCALE:
            begin
                mul_a = {15'd0, pw_reg};
                mul_b = {16'd0, range_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign log_sq        = mul_p[61:30];
    assign log_m_step    = log_sq[31] ? log_sq[31:1] : log_sq[30:0];
    assign log_frac_step = {log_frac_reg[14:0], log_sq[31]};
    assign neglog_step   = LOG_TOP - {1'b0, log_e_reg, log_frac_step};

    always_comb
    begin
        unique case (state_reg)
            ST_AVG_DIV: log_x = tgt_eff;
            ST_LOG_TGT: log_x = avg_reg;
            default:    log_x = div_quo_step[15:0];
        endcase
    end

    always_comb
    begin
        log_e_x = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (log_x[i]) begin
                log_e_x = 4'(i);
            end
        end
    end

    assign log_m_x = {15'd0, log_x} << (5'd30 - {1'b0, log_e_x});

    assign pow_sum   = mul_p + 64'h2000_0000;
    assign t_sum     = mul_p[36:0] + 37'd2048;
    assign t_k       = t_sum[36:28];
    assign pow_round = {14'd0, pow_r_reg} + (45'd1 << (6'(pow_k_reg) + 6'd13));
    assign pow_shift = pow_round >> (6'(pow_k_reg) + 6'd14);
    assign scale_sum = mul_p[32:0] + 33'd32768;
    assign scale_res = {base_reg[PIX_W-1], base_reg} + scale_sum[32:16];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc) begin
                    if (req.req_type == REQ_LOAD) begin
                        if (!phase_reg && req.slice_end) begin
                            state_next = ST_FIN;
                        end
                    end
                    else if (phase_reg && (rp_reg < count_reg)) begin
                        state_next = ST_F_RD;
                    end
                end
            end
            ST_FIN:     state_next = flat_now ? ST_IDLE : ST_W_RD;
            ST_W_RD:    state_next = ST_W_LOAD;
            ST_W_LOAD:  state_next = ST_W_NORM;
            ST_W_NORM:
            begin
                if (step_last) begin
                    state_next = rp_is_last ? ST_AVG : ST_W_RD;
                end
            end
            ST_AVG:     state_next = (cnt_reg == '0) ? ST_IDLE : ST_AVG_DIV;
            ST_AVG_DIV:
            begin
                if (step_last) begin
                    state_next = (div_quo_step == '0 || div_quo_step >= DIV_N_W'(ONE_Q16))
                                 ? ST_IDLE : ST_LOG_TGT;
                end
            end
            ST_LOG_TGT: state_next = step_last ? ST_LOG_AVG : ST_LOG_TGT;
            ST_LOG_AVG: state_next = step_last ? ST_G_DIV : ST_LOG_AVG;
            ST_G_DIV:   state_next = step_last ? ST_IDLE : ST_G_DIV;
            ST_F_RD:    state_next = (flat_reg || gamma_reg == ONE_Q12) ? ST_F_PUT : ST_F_NORM;
            ST_F_NORM:
            begin
                if (step_last) begin
                    state_next = (gamma_reg == 16'd0 || n_q == 17'd0 || n_q[16])
                                 ? ST_F_SCALE : ST_F_LOG;
                end
            end
            ST_F_LOG:   state_next = step_last ? ST_F_T : ST_F_LOG;
            ST_F_T:     state_next = (t_k >= 9'd31) ? ST_F_SCALE : ST_F_POW;
            ST_F_POW:   state_next = step_last ? ST_F_SHIFT : ST_F_POW;
            ST_F_SHIFT: state_next = ST_F_SCALE;
            ST_F_SCALE: state_next = ST_F_PUT;
            ST_F_PUT:   state_next = slot_free ? ST_IDLE : ST_F_PUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        rp_next        = rp_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        gamma_next     = gamma_reg;
        tgt_next       = tgt_reg;
        thr_next       = thr_reg;
        base_next      = base_reg;
        range_next     = range_reg;
        flat_next      = flat_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        avg_next       = avg_reg;
        lg_next        = lg_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        step_next      = step_reg;
        log_m_next     = log_m_reg;
        log_frac_next  = log_frac_reg;
        log_e_next     = log_e_reg;
        pow_r_next     = pow_r_reg;
        pow_f_next     = pow_f_reg;
        pow_k_next     = pow_k_reg;
        pw_next        = pw_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        out_gamma_next = out_gamma_reg;

        if (cfg_we) begin
            unique case (paddr[2])
                REG_TARGET: tgt_next = pwdata[15:0];
                REG_THRESH: thr_next = pwdata[15:0];
                default:    tgt_next = tgt_reg;
            endcase
        end

        if (rsp.valid && rsp.ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc) begin
                    if (req.req_type == REQ_LOAD) begin
                        if (!phase_reg && !count_reg[CNT_W-1]) begin
                            count_next = CNT_W'(count_reg + 1'b1);
                            if (req.pixel_in < min_reg) min_next = req.pixel_in;
                            if (req.pixel_in > max_reg) max_next = req.pixel_in;
                        end
                    end
                    else if (phase_reg) begin
                        if (rp_reg < count_reg) begin
                            last_next = rp_is_last;
                            rp_next   = CNT_W'(rp_reg + 1'b1);
                        end
                        if (!(rp_reg < count_reg) || rp_is_last) begin
                            phase_next = 1'b0;
                            count_next = '0;
                            rp_next    = '0;
                            min_next   = PIX_MAX;
                            max_next   = PIX_MIN;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                gamma_next = ONE_Q12;
                phase_next = 1'b1;
                rp_next    = '0;
                flat_next  = flat_now;
                base_next  = min_reg;
                range_next = 16'(max_reg - min_reg);
                sum_next   = '0;
                cnt_next   = '0;
            end
            ST_W_LOAD, ST_F_RD:
            begin
                div_num_next = norm_num;
                div_den_next = DIV_D_W'(range_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                step_next    = 6'(DIV_N_W - 1);
                if (state_reg == ST_F_RD) begin
                    res_next = mem_q_reg;
                end
            end
            ST_W_NORM, ST_AVG_DIV, ST_G_DIV, ST_F_NORM:
            begin
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
                step_next    = step_reg - 6'd1;
                if (step_last) begin
                    unique case (state_reg)
                        ST_W_NORM:
                        begin
                            if (n_q > {1'b0, thr_reg}) begin
                                sum_next = sum_reg + 29'(n_q);
                                cnt_next = CNT_W'(cnt_reg + 1'b1);
                            end
                            rp_next = rp_is_last ? '0 : CNT_W'(rp_reg + 1'b1);
                        end
                        ST_AVG_DIV:
                        begin
                            avg_next      = div_quo_step[15:0];
                            log_m_next    = log_m_x;
                            log_e_next    = log_e_x;
                            log_frac_next = '0;
                            step_next     = 6'(LOG_STEPS - 1);
                        end
                        ST_G_DIV:
                        begin
                            gamma_next = (div_quo_step[DIV_N_W-1:16] != '0) ? 16'hFFFF
                                                                          : div_quo_step[15:0];
                        end
                        default:
                        begin
                            if (gamma_reg == 16'd0 || n_q[16]) begin
                                pw_next = ONE_Q16;
                            end
                            else if (n_q == 17'd0) begin
                                pw_next = 17'd0;
                            end
                            else begin
                                log_m_next    = log_m_x;
                                log_e_next    = log_e_x;
                                log_frac_next = '0;
                                step_next     = 6'(LOG_STEPS - 1);
                            end
                        end
                    endcase
                end
            end
            ST_AVG:
            begin
                div_num_next = DIV_N_W'(sum_reg) + DIV_N_W'(cnt_reg[CNT_W-1:1]);
                div_den_next = DIV_D_W'(cnt_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                step_next    = 6'(DIV_N_W - 1);
            end
            ST_LOG_TGT, ST_LOG_AVG, ST_F_LOG:
            begin
                log_m_next    = log_m_step;
                log_frac_next = log_frac_step;
                step_next     = step_reg - 6'd1;
                if (step_last) begin
                    lg_next = neglog_step;
                    if (state_reg == ST_LOG_TGT) begin
                        log_m_next    = log_m_x;
                        log_e_next    = log_e_x;
                        log_frac_next = '0;
                        step_next     = 6'(LOG_STEPS - 1);
                    end
                    else if (state_reg == ST_LOG_AVG) begin
                        div_num_next = DIV_N_W'({lg_reg, 12'd0}) + DIV_N_W'(neglog_step[20:1]);
                        div_den_next = neglog_step;
                        div_rem_next = '0;
                        div_quo_next = '0;
                        step_next    = 6'(DIV_N_W - 1);
                    end
                end
            end
            ST_F_T:
            begin
                if (t_k >= 9'd31) begin
                    pw_next = 17'd0;
                end
                else begin
                    pow_k_next = t_k[4:0];
                    pow_f_next = t_sum[27:12];
                    pow_r_next = 31'h4000_0000;
                    step_next  = 6'(LOG_STEPS - 1);
                end
            end
            ST_F_POW:
            begin
                if (pow_f_reg[step_reg[3:0]]) begin
                    pow_r_next = pow_sum[60:30];
                end
                step_next = step_reg - 6'd1;
            end
            ST_F_SHIFT: pw_next  = pow_shift[16:0];
            ST_F_SCALE: res_next = scale_res[15:0];
            ST_F_PUT:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_pix_next   = res_reg;
                    out_last_next  = last_reg;
                    out_gamma_next = gamma_reg;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            rp_reg        <= '0;
            min_reg       <= PIX_MAX;
            max_reg       <= PIX_MIN;
            gamma_reg     <= ONE_Q12;
            tgt_reg       <= 16'd16384;
            thr_reg       <= 16'd6554;
            base_reg      <= '0;
            range_reg     <= '0;
            flat_reg      <= 1'b1;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            avg_reg       <= '0;
            lg_reg        <= '0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
            step_reg      <= '0;
            log_m_reg     <= '0;
            log_frac_reg  <= '0;
            log_e_reg     <= '0;
            pow_r_reg     <= '0;
            pow_f_reg     <= '0;
            pow_k_reg     <= '0;
            pw_reg        <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_gamma_reg <= '0;
        end
        else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            gamma_reg     <= gamma_next;
            tgt_reg       <= tgt_next;
            thr_reg       <= thr_next;
            base_reg      <= base_next;
            range_reg     <= range_next;
            flat_reg      <= flat_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            avg_reg       <= avg_next;
            lg_reg        <= lg_next;
            div_num_reg   <= div_num_next;
            div_den_reg   <= div_den_next;
            div_rem_reg   <= div_rem_next;
            div_quo_reg   <= div_quo_next;
            step_reg      <= step_next;
            log_m_reg     <= log_m_next;
            log_frac_reg  <= log_frac_next;
            log_e_reg     <= log_e_next;
            pow_r_reg     <= pow_r_next;
            pow_f_reg     <= pow_f_next;
            pow_k_reg     <= pow_k_next;
            pw_reg        <= pw_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_last_reg  <= out_last_next;
            out_gamma_reg <= out_gamma_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[count_reg[ADDR_W-1:0]] <= req.pixel_in;
        end
        mem_q_reg <= mem[rp_reg[ADDR_W-1:0]];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count beyond store depth");

    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && phase_reg) |-> (rp_reg <= count_reg))
        else $error("read pointer past pixel count");

    a_fin_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (gamma_reg == ONE_Q12 && phase_reg && rp_reg == '0))
        else $error("slice close did not reset gamma and pointer");

    a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_POW) |-> (pow_r_reg <= 31'h4000_0000))
        else $error("power accumulator above one");

    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_PUT && !slot_free) |=> (state_reg == ST_F_PUT && !req.ready))
        else $error("result dropped on stall");

endmodule

`default_nettype wire

@@ tb/slice_auto_gamma_correct_tb.sv @@
// Self-checking testbench for slice_auto_gamma_correct: loads slices, fetches corrected words.
// Depends on sagc_pkg and sagc_if.sv; predicts each result with a fixed-point gamma model.
`timescale 1ns / 1ps

module slice_auto_gamma_correct_tb;
    import sagc_pkg::*;

    typedef struct {
        logic                    kind;
        logic signed [PIX_W-1:0] pix;
        logic                    fin;
        bit                      drain;
    } req_word_t;

    typedef struct {
        logic signed [PIX_W-1:0] pix;
        logic                    last;
        logic [15:0]             gam;
    } rsp_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sagc_req_if req ();
    sagc_rsp_if rsp ();

    slice_auto_gamma_correct i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .rsp     (rsp.source)
    );

    req_word_t pending_words[$];
    rsp_word_t expected_pixels[$];
    int        fail_count;
    int        rsp_seen;
    bit        idle_on;
    bit        rsp_hold;
    bit        req_took;
    int        req_gap;
    int        rsp_gap;

    // gamma model state
    longint      slice_store[MAX_PIXELS];
    longint      slice_lo;
    longint      slice_hi;
    int unsigned slice_len;
    int unsigned fetch_ptr;
    int unsigned gamma_q12;
    bit          fetching;
    int unsigned target_q16;
    int unsigned thresh_q16;
    logic [63:0] root_coef[1:16];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    function automatic logic [31:0] log2_q16(input int unsigned x);
        int          e;
        logic [63:0] m;
        logic [31:0] fr;
        e = 0;
        for (int i = 0; i < 16; i++)
            if (x[i])
                e = i;
        m  = 64'(x) << (30 - e);
        fr = '0;
        for (int i = 0; i < 16; i++)
        begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000)
            begin
                fr[0] = 1'b1;
                m     = m >> 1;
            end
        end
        return (32'(e) << 16) | fr;
    endfunction

    function automatic logic [31:0] neg_log(input int unsigned x);
        return (32'd16 << 16) - log2_q16(x);
    endfunction

    function automatic int unsigned raise_q16(input int unsigned n, input int unsigned g);
        logic [63:0] t;
        logic [63:0] r;
        int unsigned k;
        int unsigned f;
        if (g == 0)
            return 65536;
        if (n == 0)
            return 0;
        if (n >= 65536)
            return 65536;
        t = (64'(neg_log(n)) * 64'(g) + 64'd2048) >> 12;
        if ((t >> 16) >= 31)
            return 0;
        k = 32'(t >> 16);
        f = 32'(t & 64'hFFFF);
        r = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
            if ((f >> (16 - i)) & 1)
                r = (r * root_coef[i] + (64'd1 << 29)) >> 30;
        return 32'((r + (64'd1 << (13 + k))) >> (14 + k));
    endfunction

    function automatic int unsigned norm_q16(input longint p, input longint span);
        longint d;
        d = p - slice_lo;
        return 32'((d * 65536 + span / 2) / span);
    endfunction

    function automatic void restart_slice();
        slice_lo  = 32767;
        slice_hi  = -32768;
        slice_len = 0;
        fetch_ptr = 0;
        fetching  = 0;
    endfunction

    function automatic void close_slice();
        longint      span;
        longint      sum;
        int unsigned cnt;
        int unsigned n;
        int unsigned avg;
        int unsigned tgt;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] g;
        gamma_q12 = 4096;
        fetching  = 1;
        fetch_ptr = 0;
        if (slice_hi <= slice_lo)
            return;
        span = slice_hi - slice_lo;
        sum  = 0;
        cnt  = 0;
        for (int i = 0; i < slice_len; i++)
        begin
            n = norm_q16(slice_store[i], span);
            if (n > thresh_q16)
            begin
                sum += n;
                cnt++;
            end
        end
        if (cnt == 0)
            return;
        avg = 32'((sum + longint'(cnt / 2)) / longint'(cnt));
        if (avg >= 65536 || avg == 0)
            return;
        tgt = (target_q16 == 0) ? 1 : target_q16;
        num = 64'(neg_log(tgt));
        den = 64'(neg_log(avg));
        g   = (num * 4096 + den / 2) / den;
        gamma_q12 = (g > 65535) ? 65535 : 32'(g);
    endfunction

    function automatic void predict_word(input logic kind, input logic signed [15:0] pin,
                                         input logic fin);
        longint    p;
        longint    span;
        rsp_word_t w;
        if (kind == REQ_LOAD)
        begin
            if (fetching)
                return;
            p = pin;
            if (slice_len < MAX_PIXELS)
            begin
                slice_store[slice_len] = p;
                slice_len++;
                if (p < slice_lo)
                    slice_lo = p;
                if (p > slice_hi)
                    slice_hi = p;
            end
            if (fin)
                close_slice();
            return;
        end
        if (!fetching || fetch_ptr >= slice_len)
        begin
            if (fetching)
                restart_slice();
            return;
        end
        p      = slice_store[fetch_ptr];
        w.last = (fetch_ptr + 1 == slice_len);
        if (slice_hi > slice_lo && gamma_q12 != 4096)
        begin
            span = slice_hi - slice_lo;
            p = slice_lo + ((longint'(raise_q16(norm_q16(p, span), gamma_q12)) * span
                             + 32768) >>> 16);
        end
        w.pix = p[15:0];
        w.gam = gamma_q12[15:0];
        expected_pixels.push_back(w);
        fetch_ptr++;
        if (w.last)
            restart_slice();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        logic      v;
        req_word_t w;
        v = req.valid;
        if (!(req.valid && !req_took))
        begin
            v = 1'b0;
            if (req_gap > 0)
                req_gap--;
            else if (pending_words.size() > 0)
            begin
                if (pending_words[0].drain)
                begin
                    if (expected_pixels.size() == 0)
                        void'(pending_words.pop_front());
                end
                else
                begin
                    w             = pending_words.pop_front();
                    v             = 1'b1;
                    req.req_type  <= w.kind;
                    req.pixel_in  <= w.pix;
                    req.slice_end <= w.fin;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        req_gap = $urandom_range(1, 14);
                end
            end
        end
        req.valid <= v;
    end

    // response ready with bursts of back-pressure
    always @(negedge clk)
    begin
        logic r;
        r = 1'b1;
        if (rsp_hold)
            r = 1'b0;
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            r = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rsp_gap = $urandom_range(1, 14) - 1;
            r = 1'b0;
        end
        rsp.ready <= r;
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_word_t e;
        req_took <= req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
            predict_word(req.req_type, req.pixel_in, req.slice_end);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_seen++;
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected word", rsp.pixel_out, 0);
            else
            begin
                e = expected_pixels.pop_front();
                if (rsp.pixel_out !== e.pix)
                    report_mismatch("pixel_out", rsp.pixel_out, e.pix);
                if (rsp.last_out !== e.last)
                    report_mismatch("last_out", rsp.last_out, e.last);
                if (rsp.gamma_used !== e.gam)
                    report_mismatch("gamma_used", rsp.gamma_used, e.gam);
            end
        end
    end

    // long receiver hold-off while the sender keeps offering words
    initial
    begin
        rsp_hold = 1'b0;
        wait (rsp_seen >= 150);
        @(negedge clk);
        rsp_hold = 1'b1;
        repeat (600) @(posedge clk);
        @(negedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    task automatic push_word(input logic kind, input int pix, input logic fin);
        req_word_t w;
        w.kind  = kind;
        w.pix   = pix[15:0];
        w.fin   = fin;
        w.drain = 0;
        pending_words.push_back(w);
    endtask

    task automatic push_drain();
        req_word_t w;
        w = '{kind: 0, pix: 0, fin: 0, drain: 1};
        pending_words.push_back(w);
    endtask

    function automatic int draw_pixel(input int style, input int center, input int spread);
        int v;
        case (style)
            0: v = $signed(16'($urandom));
            1: v = center + $urandom_range(0, spread) - spread / 2;
            2: v = center;
            default: v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 50)
                                              : -32768 + $urandom_range(0, 50);
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic push_slice(input int len, input int style);
        int center;
        int spread;
        center = $signed(16'($urandom));
        spread = $urandom_range(1, 4000);
        if ($urandom_range(0, 9) == 0)
            push_word(REQ_FETCH, 0, 0);
        for (int i = 0; i < len; i++)
            push_word(REQ_LOAD, draw_pixel(style, center, spread), i == len - 1);
        for (int i = 0; i < len; i++)
        begin
            push_word(REQ_FETCH, 0, 0);
            if (i == 0 && $urandom_range(0, 9) == 0)
                push_word(REQ_LOAD, $signed(16'($urandom)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic settle();
        wait (pending_words.size() == 0 && expected_pixels.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TARGET)
            target_q16 = data[15:0];
        else
            thresh_q16 = data[15:0];
    endtask

    initial
    begin
        int tgts[6];
        int ths[6];
        fail_count    = 0;
        rsp_seen      = 0;
        idle_on       = 1'b1;
        req_gap       = 0;
        rsp_gap       = 0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req.valid     = 1'b0;
        req.req_type  = REQ_LOAD;
        req.pixel_in  = '0;
        req.slice_end = 1'b0;
        rsp.ready     = 1'b0;
        req_took      = 1'b0;
        target_q16    = 16384;
        thresh_q16    = 6554;
        gamma_q12     = 4096;
        restart_slice();
        root_coef[1] = floor_sqrt(64'd1 << 59);
        for (int i = 2; i <= 16; i++)
            root_coef[i] = floor_sqrt(root_coef[i-1] << 30);
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: stray fetch, extremes, flat slice, gamma one, stray load
        push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, -32768, 0);
        push_word(REQ_LOAD, 32767, 0);
        push_word(REQ_LOAD, 0, 0);
        push_word(REQ_LOAD, -1, 0);
        push_word(REQ_LOAD, 21845, 1);
        for (int i = 0; i < 5; i++)
            push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, 7, 1);
        push_word(REQ_LOAD, 7, 1);
        push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, -5, 0);
        push_word(REQ_LOAD, -5, 1);
        push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, 100, 0);
        push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, 4, 1);
        push_word(REQ_FETCH, 0, 0);
        push_word(REQ_LOAD, 9, 0);
        push_word(REQ_FETCH, 0, 0);
        push_drain();
        settle();

        tgts = '{16384, 0, 65535, 1, 52000, 3000};
        ths  = '{6554, 65535, 0, 0, 30000, 1000};
        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(REG_TARGET, tgts[ph]);
            apb_write(REG_THRESH, ths[ph]);
            for (int s = 0; s < 6; s++)
            begin
                push_slice(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                       : $urandom_range(2, 10),
                           $urandom_range(0, 3));
                if (s == 2)
                    push_drain();
            end
            settle();
        end

        // back-to-back slices, no idling
        idle_on = 1'b0;
        apb_write(REG_TARGET, 16384);
        apb_write(REG_THRESH, 6554);
        for (int s = 0; s < 4; s++)
            push_slice($urandom_range(2, 10), $urandom_range(0, 3));
        settle();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
